[hw/rtl/nfha_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared constants and helpers of the next-fit heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

	localparam int HEAP_WORDS = 4096;
	localparam int ADDR_W     = $clog2(HEAP_WORDS);
	localparam int WORD_W     = 16;
	localparam int OFF_W      = 15;  // byte offsets 0..16384
	localparam int CNT_W      = 12;  // walk steps 0..2049

	localparam int MAX_HEAP   = 16384;
	localparam int CAP_RAW    = (HEAP_WORDS * 4) - ((HEAP_WORDS * 4) % 8);
	localparam int CAP_BYTES  = (CAP_RAW > MAX_HEAP) ? MAX_HEAP : CAP_RAW;

	localparam logic [WORD_W-1:0] A_BIT = 16'd1;
	localparam logic [WORD_W-1:0] P_BIT = 16'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
	localparam logic [2:0] ST_BAD_PTR   = 3'd3;
	localparam logic [2:0] ST_ALR_FREE  = 3'd4;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Byte offset to store word index.
	function automatic logic [ADDR_W-1:0] off2idx(input logic [OFF_W+1:0] off);
		off2idx = ADDR_W'(off >> 2);
	endfunction

	// Effective heap size from the register value.
	function automatic logic [OFF_W-1:0] eff_limit(input logic [14:0] hb);
		logic [OFF_W-1:0] l;
		l = OFF_W'(hb) & ~OFF_W'(7);
		if (l > OFF_W'(CAP_BYTES)) l = OFF_W'(CAP_BYTES);
		if (l < OFF_W'(16)) l = OFF_W'(16);
		eff_limit = l;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/nfha_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nfha_ram
// Single-port synchronous RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module nfha_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/next_fit_heap_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_heap_allocator
// Next-fit boundary-tag allocator over a word store of 16-bit heap tags.
// ----------------------------------------------------------------------------
//  channel   dir  payload (low bit first)
//  s_axis    in   tuser: func; tdata: req_bytes[14:0], payload_addr[28:15]
//  m_axis    out  tuser: ok;   tdata: status[2:0], result_addr[16:3]
//  cfg       in   cfg_data: heap_bytes[14:0]
//
//  Every store access uses the single RAM port; a walk step is a read issue
//  followed by a tag check. Allocate walks blocks from the rover on; free
//  walks the blocks from heap start to the target. Both walks are bounded
//  by heap_bytes/8 + 1 steps.
//  After reset and after every cfg transfer the store is swept once over all
//  HEAP_WORDS words, writing the fresh free block; no request is taken then.
//  A finished result sits in the output register; the next request is taken
//  while it waits, and the following result stalls until it is transferred.
// ----------------------------------------------------------------------------
module next_fit_heap_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // req_bytes, payload_addr
	input  wire logic [0:0]  s_axis_tuser,   // func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // status, result_addr
	output logic [0:0]       m_axis_tuser,   // ok
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data        // heap_bytes
);

	import nfha_pkg::*;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_ARD   = 5'd2;
	localparam logic [4:0] S_ACHK  = 5'd3;
	localparam logic [4:0] S_AW1   = 5'd4;
	localparam logic [4:0] S_ANRD  = 5'd5;
	localparam logic [4:0] S_ANW   = 5'd6;
	localparam logic [4:0] S_AW2   = 5'd7;
	localparam logic [4:0] S_AW3   = 5'd8;
	localparam logic [4:0] S_FRD   = 5'd9;
	localparam logic [4:0] S_FCHK  = 5'd10;
	localparam logic [4:0] S_FHRD  = 5'd11;
	localparam logic [4:0] S_FHCHK = 5'd12;
	localparam logic [4:0] S_FNCHK = 5'd13;
	localparam logic [4:0] S_FSRD  = 5'd14;
	localparam logic [4:0] S_FSW   = 5'd15;
	localparam logic [4:0] S_FFW   = 5'd16;
	localparam logic [4:0] S_FTRD  = 5'd17;
	localparam logic [4:0] S_FTW   = 5'd18;
	localparam logic [4:0] S_DONE  = 5'd19;

	logic [4:0]        state_q, state_d;
	logic [OFF_W-1:0]  lim_q;
	logic [13:0]       rover_q, rover_d;
	logic [ADDR_W-1:0] clr_q;
	logic [OFF_W-1:0]  pos_q, pos_d, start_q, start_d, need_q, need_d;
	logic [OFF_W-1:0]  h_q, h_d, sz_q, sz_d, prev_q, prev_d, st_q, st_d, tot_q, tot_d;
	logic [WORD_W-1:0] hd_q, hd_d;
	logic              pfree_q, pfree_d, nxv_q, nxv_d, exact_q, exact_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [2:0]        rst_q, rst_d;
	logic [13:0]       raddr_q, raddr_d;

	logic              out_v_q, out_ok_q;
	logic [2:0]        out_st_q;
	logic [13:0]       out_addr_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_idx;
	logic [WORD_W-1:0] mem_wd, mem_rd;

	logic [WORD_W-1:0] tag_sz;
	logic [OFF_W+1:0]  tag_end, nsz_w, nx_end, ft_off, np_w;
	logic [OFF_W+1:0]  need_w;
	logic [OFF_W-1:0]  hin;
	logic              accept, done_go;
	logic [CNT_W-1:0]  bound;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign done_go = (state_q == S_DONE) && (!out_v_q || m_axis_tready);
	assign bound   = CNT_W'(lim_q >> 3);
	assign tag_sz  = mem_rd & ~(A_BIT | P_BIT);
	assign hin     = OFF_W'(s_axis_tdata[28:15]) - OFF_W'(4);

	nfha_ram #(.DEPTH(HEAP_WORDS), .WIDTH(WORD_W)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_idx),
		.wdata (mem_wd),
		.rdata (mem_rd)
	);

	// Store port: one access per cycle, chosen by the sequencer state.
	always_comb begin
		mem_we  = 1'b0;
		mem_idx = '0;
		mem_wd  = '0;
		ft_off  = {2'b00, st_q} + {2'b00, tot_q} - (OFF_W+2)'(4);
		unique case (state_q)
			S_CLR: begin
				mem_we  = 1'b1;
				mem_idx = clr_q[ADDR_W-1:0];
				if (clr_q[ADDR_W-1:0] == '0) begin
					mem_wd = WORD_W'(lim_q) | P_BIT;
				end else if (clr_q[ADDR_W-1:0] == off2idx({2'b00, lim_q} - (OFF_W+2)'(4))) begin
					mem_wd = WORD_W'(lim_q);
				end
			end
			S_ARD, S_FRD: mem_idx = off2idx({2'b00, pos_q});
			S_AW1: begin
				mem_we  = 1'b1;
				mem_idx = off2idx({2'b00, pos_q});
				mem_wd  = exact_q ? (hd_q | A_BIT)
				                  : (WORD_W'(need_q) | A_BIT | (hd_q & P_BIT));
			end
			S_ANRD: mem_idx = off2idx({2'b00, pos_q} + {2'b00, sz_q});
			S_ANW: begin
				mem_we  = 1'b1;
				mem_idx = off2idx({2'b00, pos_q} + {2'b00, sz_q});
				mem_wd  = mem_rd | P_BIT;
			end
			S_AW2: begin
				mem_we  = 1'b1;
				mem_idx = off2idx({2'b00, pos_q} + {2'b00, need_q});
				mem_wd  = WORD_W'(sz_q - need_q) | P_BIT;
			end
			S_AW3: begin
				mem_we  = 1'b1;
				mem_idx = off2idx({2'b00, pos_q} + {2'b00, sz_q} - (OFF_W+2)'(4));
				mem_wd  = WORD_W'(sz_q - need_q);
			end
			S_FHRD: mem_idx = off2idx({2'b00, h_q});
			S_FHCHK: mem_idx = off2idx({2'b00, h_q} + (OFF_W+2)'(tag_sz));
			S_FSRD: mem_idx = off2idx({2'b00, st_q});
			S_FSW: begin
				mem_we  = 1'b1;
				mem_idx = off2idx({2'b00, st_q});
				mem_wd  = WORD_W'(tot_q) | (mem_rd & P_BIT);
			end
			S_FFW: begin
				mem_we  = 1'b1;
				mem_idx = off2idx(ft_off);
				mem_wd  = WORD_W'(tot_q);
			end
			S_FTRD: mem_idx = off2idx({2'b00, st_q} + {2'b00, tot_q});
			S_FTW: begin
				mem_we  = 1'b1;
				mem_idx = off2idx({2'b00, st_q} + {2'b00, tot_q});
				mem_wd  = mem_rd & ~P_BIT;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		rover_d = rover_q;
		pos_d   = pos_q;   start_d = start_q; need_d = need_q;
		h_d     = h_q;     sz_d    = sz_q;    prev_d = prev_q;
		st_d    = st_q;    tot_d   = tot_q;   hd_d   = hd_q;
		pfree_d = pfree_q; nxv_d   = nxv_q;   exact_d = exact_q;
		cnt_d   = cnt_q;   rst_d   = rst_q;   raddr_d = raddr_q;
		tag_end = {2'b00, pos_q} + (OFF_W+2)'(tag_sz);
		np_w    = tag_end;
		nsz_w   = '0;
		nx_end  = '0;
		need_w  = ((OFF_W+2)'(s_axis_tdata[14:0]) + (OFF_W+2)'(11)) & ~(OFF_W+2)'(7);
		unique case (state_q)
			S_CLR: ;
			S_IDLE: begin
				if (accept) begin
					cnt_d   = '0;
					raddr_d = '0;
					if (s_axis_tuser[0] == FUNC_ALLOC) begin
						need_d = OFF_W'(need_w);
						pos_d  = ({1'b0, rover_q} < lim_q) ? {1'b0, rover_q} : '0;
						start_d = ({1'b0, rover_q} < lim_q) ? {1'b0, rover_q} : '0;
						if (s_axis_tdata[14:0] == '0 || s_axis_tdata[14:0] > lim_q) begin
							rst_d   = ST_BAD_SIZE;
							state_d = S_DONE;
						end else begin
							state_d = S_ARD;
						end
					end else begin
						h_d     = hin;
						pos_d   = '0;
						prev_d  = '0;
						pfree_d = 1'b0;
						if (s_axis_tdata[17:15] != 3'd4 || hin >= lim_q) begin
							rst_d   = ST_BAD_PTR;
							state_d = S_DONE;
						end else begin
							state_d = S_FRD;
						end
					end
				end
			end
			S_ARD: begin
				if (cnt_q > bound) begin
					rst_d   = ST_NO_FIT;
					state_d = S_DONE;
				end else begin
					state_d = S_ACHK;
				end
			end
			S_ACHK: begin
				hd_d = mem_rd;
				sz_d = OFF_W'(tag_sz);
				if (tag_sz < WORD_W'(8) || tag_end > (OFF_W+2)'(lim_q)) begin
					rst_d   = ST_NO_FIT;
					state_d = S_DONE;
				end else if (!mem_rd[0] && tag_sz >= WORD_W'(need_q)) begin
					exact_d = (tag_sz == WORD_W'(need_q));
					nxv_d   = tag_end < (OFF_W+2)'(lim_q);
					rover_d = pos_q[13:0];
					raddr_d = pos_q[13:0] + 14'd4;
					rst_d   = ST_OK;
					state_d = S_AW1;
				end else begin
					if (np_w >= (OFF_W+2)'(lim_q)) np_w = '0;
					pos_d = OFF_W'(np_w);
					cnt_d = cnt_q + CNT_W'(1);
					if (OFF_W'(np_w) == start_q) begin
						rst_d   = ST_NO_FIT;
						state_d = S_DONE;
					end else begin
						state_d = S_ARD;
					end
				end
			end
			S_AW1: begin
				if (!exact_q)     state_d = S_AW2;
				else if (nxv_q)   state_d = S_ANRD;
				else              state_d = S_DONE;
			end
			S_ANRD: state_d = S_ANW;
			S_ANW:  state_d = S_DONE;
			S_AW2:  state_d = S_AW3;
			S_AW3:  state_d = S_DONE;
			S_FRD: begin
				if (cnt_q > bound || pos_q > h_q) begin
					rst_d   = ST_BAD_PTR;
					state_d = S_DONE;
				end else if (pos_q == h_q) begin
					state_d = S_FHRD;
				end else begin
					state_d = S_FCHK;
				end
			end
			S_FCHK: begin
				prev_d  = pos_q;
				pfree_d = !mem_rd[0];
				pos_d   = OFF_W'(tag_end);
				cnt_d   = cnt_q + CNT_W'(1);
				if (tag_sz < WORD_W'(8) || tag_end >= (OFF_W+2)'(lim_q)) begin
					rst_d   = ST_BAD_PTR;
					state_d = S_DONE;
				end else begin
					state_d = S_FRD;
				end
			end
			S_FHRD: state_d = S_FHCHK;
			S_FHCHK: begin
				hd_d    = mem_rd;
				sz_d    = OFF_W'(tag_sz);
				nx_end  = {2'b00, h_q} + (OFF_W+2)'(tag_sz);
				nxv_d   = nx_end < (OFF_W+2)'(lim_q);
				if (tag_sz < WORD_W'(8) || nx_end > (OFF_W+2)'(lim_q)) begin
					rst_d   = ST_BAD_PTR;
					state_d = S_DONE;
				end else if (!mem_rd[0]) begin
					rst_d   = ST_ALR_FREE;
					state_d = S_DONE;
				end else begin
					state_d = S_FNCHK;
				end
			end
			S_FNCHK: begin
				nx_end = {2'b00, h_q} + {2'b00, sz_q};
				if (nxv_q && !mem_rd[0]) begin
					nsz_w = (OFF_W+2)'(tag_sz);
					if (nx_end + nsz_w > (OFF_W+2)'(lim_q)) nsz_w = '0;
				end
				st_d  = (h_q != '0 && pfree_q) ? prev_q : h_q;
				tot_d = (h_q - ((h_q != '0 && pfree_q) ? prev_q : h_q)) + sz_q
				        + OFF_W'(nsz_w);
				state_d = S_FSRD;
			end
			S_FSRD: state_d = S_FSW;
			S_FSW:  state_d = S_FFW;
			S_FFW: begin
				// Pull the rover back to the head of the merged block.
				if ({1'b0, rover_q} >= st_q &&
				    {2'b00, rover_q} < {2'b00, st_q} + {2'b00, tot_q}) begin
					rover_d = st_q[13:0];
				end
				rst_d = ST_OK;
				if ({2'b00, st_q} + {2'b00, tot_q} < (OFF_W+2)'(lim_q)) state_d = S_FTRD;
				else state_d = S_DONE;
			end
			S_FTRD: state_d = S_FTW;
			S_FTW:  state_d = S_DONE;
			S_DONE: if (done_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			lim_q   <= eff_limit(15'd16384);
			rover_q <= '0;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				// Reformat: restart the sweep with the new size.
				lim_q   <= eff_limit(cfg_data);
				rover_q <= '0;
				clr_q   <= '0;
				state_q <= S_CLR;
			end else if (state_q == S_CLR) begin
				clr_q <= clr_q + ADDR_W'(1);
				if (clr_q[ADDR_W-1:0] == ADDR_W'(HEAP_WORDS - 1)) state_q <= S_IDLE;
			end else begin
				state_q <= state_d;
				rover_q <= rover_d;
			end
			if (done_go) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
		end
	end

	// Working registers, no reset needed.
	always_ff @(posedge clk) begin
		pos_q <= pos_d;  start_q <= start_d; need_q <= need_d;
		h_q   <= h_d;    sz_q    <= sz_d;    prev_q <= prev_d;
		st_q  <= st_d;   tot_q   <= tot_d;   hd_q   <= hd_d;
		pfree_q <= pfree_d; nxv_q <= nxv_d;  exact_q <= exact_d;
		cnt_q <= cnt_d;  rst_q   <= rst_d;   raddr_q <= raddr_d;
		if (done_go) begin
			out_ok_q   <= (rst_q == ST_OK);
			out_st_q   <= rst_q;
			out_addr_q <= raddr_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_ok_q;
	assign m_axis_tdata  = {7'd0, out_addr_q, out_st_q};

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !s_axis_tready)
		else $error("request taken during format sweep");
	a_ok_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[2:0] == ST_OK)))
		else $error("ok flag disagrees with status");
	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[16:3] == 14'd0)
		else $error("failed request carries an address");
	a_rover_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rover_q} < lim_q)
		else $error("rover outside heap");
	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != S_CLR |-> mem_idx < off2idx({2'b00, lim_q}) ||
		lim_q == OFF_W'(HEAP_WORDS * 4))
		else $error("tag write beyond heap");

endmodule
`default_nettype wire
